@@ design/stepping_clock_pulse_controller_defines.svh @@
// Assertion macros for the checker file of the stepping clock pulse controller.
`ifndef STEPPING_CLOCK_PULSE_CONTROLLER_DEFINES_SVH
`define STEPPING_CLOCK_PULSE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SCPC_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SCPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/scpc_pkg.sv @@
// Package: types, codes and constants of the stepping clock pulse controller.
`timescale 1ns / 1ps
package scpc_pkg;

    localparam int unsigned DIAL_SECONDS = 43200;
    localparam int unsigned PADDR_W      = 5;

    // Item opcodes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_SECOND = 2'd2;
    localparam logic [1:0] OP_MS     = 2'd3;

    // Item register indexes
    localparam logic [1:0] REG_POS    = 2'd0;
    localparam logic [1:0] REG_PEND   = 2'd1;
    localparam logic [1:0] REG_CTRL   = 2'd2;
    localparam logic [1:0] REG_STATUS = 2'd3;

    // Configuration register indexes (word address)
    localparam logic [2:0] CFG_TICK_PULSE  = 3'd0;
    localparam logic [2:0] CFG_TICK_DUTY   = 3'd1;
    localparam logic [2:0] CFG_ADJ_PULSE   = 3'd2;
    localparam logic [2:0] CFG_ADJ_DUTY    = 3'd3;
    localparam logic [2:0] CFG_ADJ_GAP     = 3'd4;
    localparam logic [2:0] CFG_ADJ_FIRST   = 3'd5;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PULSE = 2'd1,
        PH_GAP   = 2'd2
    } scpc_phase_t;

    typedef struct packed {
        logic [7:0] tick_pulse_ms;
        logic [7:0] tick_duty;
        logic [7:0] adjust_pulse_ms;
        logic [7:0] adjust_duty;
        logic [7:0] adjust_gap_ms;
        logic [7:0] adjust_first_pulse_ms;
    } scpc_cfg_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [1:0]  reg_index;
        logic [15:0] write_data;
    } scpc_item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        pulse_on;
        logic        coil_select;
        logic [7:0]  pulse_duty;
        logic [15:0] dial_position;
        logic        catching_up;
    } scpc_result_t;

endpackage

@@ design/scpc_in_if.sv @@
// Interface: input item channel (valid, ready and item fields).
`timescale 1ns / 1ps
interface scpc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [1:0]  reg_index;
    logic [15:0] write_data;

    modport source (output valid, opcode, reg_index, write_data, input ready);
    modport sink   (input valid, opcode, reg_index, write_data, output ready);
endinterface

@@ design/scpc_out_if.sv @@
// Interface: result item channel (valid, ready and result fields).
`timescale 1ns / 1ps
interface scpc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic        pulse_on;
    logic        coil_select;
    logic [7:0]  pulse_duty;
    logic [15:0] dial_position;
    logic        catching_up;

    modport source (output valid, read_data, pulse_on, coil_select, pulse_duty,
                    dial_position, catching_up, input ready);
    modport sink   (input valid, read_data, pulse_on, coil_select, pulse_duty,
                    dial_position, catching_up, output ready);
endinterface

@@ design/scpc_cfg_regs.sv @@
// APB-style configuration register file for the pulse timing settings.
`timescale 1ns / 1ps
module scpc_cfg_regs
    import scpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output scpc_cfg_t          cfg
);

    scpc_cfg_t  cfg_reg;
    logic       wr_en;
    logic [2:0] word_idx;
    logic [7:0] rd_byte;

    assign pready   = 1'b1;
    assign word_idx = paddr[PADDR_W-1:2];
    assign wr_en    = psel && penable && pwrite && pready;
    assign cfg      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_pulse_ms         <= 8'd32;
            cfg_reg.tick_duty             <= 8'd60;
            cfg_reg.adjust_pulse_ms       <= 8'd16;
            cfg_reg.adjust_duty           <= 8'd80;
            cfg_reg.adjust_gap_ms         <= 8'd100;
            cfg_reg.adjust_first_pulse_ms <= 8'd32;
        end
        else if (wr_en)
        begin
            case (word_idx)
                CFG_TICK_PULSE: cfg_reg.tick_pulse_ms         <= pwdata[7:0];
                CFG_TICK_DUTY:  cfg_reg.tick_duty             <= pwdata[7:0];
                CFG_ADJ_PULSE:  cfg_reg.adjust_pulse_ms       <= pwdata[7:0];
                CFG_ADJ_DUTY:   cfg_reg.adjust_duty           <= pwdata[7:0];
                CFG_ADJ_GAP:    cfg_reg.adjust_gap_ms         <= pwdata[7:0];
                CFG_ADJ_FIRST:  cfg_reg.adjust_first_pulse_ms <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (word_idx)
            CFG_TICK_PULSE: rd_byte = cfg_reg.tick_pulse_ms;
            CFG_TICK_DUTY:  rd_byte = cfg_reg.tick_duty;
            CFG_ADJ_PULSE:  rd_byte = cfg_reg.adjust_pulse_ms;
            CFG_ADJ_DUTY:   rd_byte = cfg_reg.adjust_duty;
            CFG_ADJ_GAP:    rd_byte = cfg_reg.adjust_gap_ms;
            CFG_ADJ_FIRST:  rd_byte = cfg_reg.adjust_first_pulse_ms;
            default:        rd_byte = 8'd0;
        endcase
    end

    assign prdata = {24'd0, rd_byte};

endmodule

@@ design/scpc_core.sv @@
// Dial, catch-up and pulse timing state with the registered result stage.
`timescale 1ns / 1ps
module scpc_core
    import scpc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  scpc_cfg_t    cfg,
    input  logic         fire,
    input  scpc_item_t   item,
    input  logic         res_ready,
    output logic         res_valid,
    output scpc_result_t result
);

    logic [15:0]  pos_reg,   pos_next;
    logic [15:0]  pend_reg,  pend_next;
    logic [7:0]   ctrl_reg,  ctrl_next;
    logic         tock_reg,  tock_next;
    logic         adj_reg,   adj_next;
    scpc_phase_t  phase_reg, phase_next;
    logic [7:0]   ms_reg,    ms_next;
    logic [7:0]   duty_reg,  duty_next;
    logic         res_valid_reg, res_valid_next;
    scpc_result_t result_reg, result_next;

    logic [15:0] rd;
    logic        start;
    logic [7:0]  start_len;
    logic [7:0]  start_duty;
    logic [16:0] pos_inc;
    logic [15:0] pos_adv;

    assign pos_inc = {1'b0, pos_reg} + 17'd1;
    assign pos_adv = (pos_inc >= 17'(DIAL_SECONDS)) ? 16'd0 : pos_inc[15:0];

    always_comb
    begin
        pos_next   = pos_reg;
        pend_next  = pend_reg;
        ctrl_next  = ctrl_reg;
        tock_next  = tock_reg;
        adj_next   = adj_reg;
        phase_next = phase_reg;
        ms_next    = ms_reg;
        duty_next  = duty_reg;
        rd         = 16'd0;
        start      = 1'b0;
        start_len  = cfg.tick_pulse_ms;
        start_duty = cfg.tick_duty;

        case (item.opcode)
            OP_WRITE:
            begin
                case (item.reg_index)
                    REG_POS:  pos_next  = item.write_data;
                    REG_PEND: pend_next = item.write_data;
                    REG_CTRL: ctrl_next = item.write_data[7:0];
                    default:  ;
                endcase
            end
            OP_READ:
            begin
                case (item.reg_index)
                    REG_POS:  rd = pos_reg;
                    REG_PEND: rd = pend_reg;
                    REG_CTRL: rd = {8'd0, ctrl_reg};
                    default:  rd = {15'd0, tock_reg};
                endcase
            end
            OP_SECOND:
            begin
                if (ctrl_reg[0] && pend_reg == 16'd0)
                begin
                    start = 1'b1;
                end
                else if (pend_reg != 16'd0)
                begin
                    if (ctrl_reg[0] && pend_reg != 16'hFFFF)
                        pend_next = pend_reg + 16'd1;
                    // first catch-up step: start length, tick duty
                    if (!adj_reg)
                    begin
                        adj_next  = 1'b1;
                        start     = 1'b1;
                        start_len = cfg.adjust_first_pulse_ms;
                    end
                end
            end
            default:
            begin
                if (phase_reg == PH_PULSE || phase_reg == PH_GAP)
                begin
                    if (ms_reg > 8'd1)
                    begin
                        ms_next = ms_reg - 8'd1;
                    end
                    else if (phase_reg == PH_PULSE)
                    begin
                        tock_next  = ~tock_reg;
                        phase_next = PH_IDLE;
                        ms_next    = 8'd0;
                        duty_next  = 8'd0;
                        adj_next   = 1'b0;
                        if (pend_reg != 16'd0)
                        begin
                            pend_next = pend_reg - 16'd1;
                            if (pend_reg != 16'd1)
                            begin
                                phase_next = PH_GAP;
                                ms_next    = cfg.adjust_gap_ms;
                                adj_next   = adj_reg;
                            end
                        end
                    end
                    else
                    begin
                        start = 1'b1;
                        if (pend_reg != 16'd1)
                        begin
                            start_len  = cfg.adjust_pulse_ms;
                            start_duty = cfg.adjust_duty;
                        end
                    end
                end
            end
        endcase

        // a new pulse overrides whatever pulse or gap is running
        if (start)
        begin
            pos_next   = pos_adv;
            phase_next = PH_PULSE;
            ms_next    = start_len;
            duty_next  = start_duty;
        end
    end

    always_comb
    begin
        result_next.read_data     = rd;
        result_next.pulse_on      = (phase_next == PH_PULSE);
        result_next.coil_select   = tock_next;
        result_next.pulse_duty    = (phase_next == PH_PULSE) ? duty_next : 8'd0;
        result_next.dial_position = pos_next;
        result_next.catching_up   = adj_next;
        res_valid_next = fire ? 1'b1 : (res_valid_reg && !res_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 16'(DIAL_SECONDS - 1);
            pend_reg      <= 16'd1;
            ctrl_reg      <= 8'd0;
            tock_reg      <= 1'b0;
            adj_reg       <= 1'b0;
            phase_reg     <= PH_IDLE;
            ms_reg        <= 8'd0;
            duty_reg      <= 8'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (fire)
            begin
                pos_reg   <= pos_next;
                pend_reg  <= pend_next;
                ctrl_reg  <= ctrl_next;
                tock_reg  <= tock_next;
                adj_reg   <= adj_next;
                phase_reg <= phase_next;
                ms_reg    <= ms_next;
                duty_reg  <= duty_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            result_reg <= result_next;
    end

    assign res_valid = res_valid_reg;
    assign result    = result_reg;

endmodule

@@ design/stepping_clock_pulse_controller.sv @@
// Top level of the stepping clock pulse controller.
// Channels: items (sink) carries opcode, reg_index and write_data; results
// (source) carries one result per item, in order: read_data, pulse_on,
// coil_select, pulse_duty, dial_position and catching_up. A transfer
// happens on a rising clk edge with valid and ready both high.
// The APB-style port sets the six pulse timing registers at byte address
// 4*i; pready is tied high and reads return the stored value.
// An item taken into the input register is processed by the state update
// once the result register is free or draining, and its result is then
// held in the result register.
// Throughput: one item per cycle while the receiver takes every result,
// set by the single state update between the input and result registers.
// When the receiver stalls, the result register holds and the input
// register still takes one more item; items.ready falls only with both full.
// Reset (rst_n, asynchronous, active low) puts the dial at its last
// position, one pending step, clock disabled, no pulse running, and loads
// the default timing settings.
`timescale 1ns / 1ps
module stepping_clock_pulse_controller
    import scpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    scpc_in_if.sink            items,
    scpc_out_if.source         results,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    scpc_cfg_t    cfg;
    scpc_item_t   item_reg;
    logic         item_valid_reg, item_valid_next;
    logic         fire;
    logic         res_valid;
    scpc_result_t result;

    // input stage moves on whenever the result register is free or draining
    assign fire        = item_valid_reg && (!res_valid || results.ready);
    assign items.ready = !item_valid_reg || fire;

    always_comb
    begin
        item_valid_next = (items.valid && items.ready) ? 1'b1 :
                          (item_valid_reg && !fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            item_reg.opcode     <= items.opcode;
            item_reg.reg_index  <= items.reg_index;
            item_reg.write_data <= items.write_data;
        end
    end

    scpc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    scpc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .fire      (fire),
        .item      (item_reg),
        .res_ready (results.ready),
        .res_valid (res_valid),
        .result    (result)
    );

    assign results.valid         = res_valid;
    assign results.read_data     = result.read_data;
    assign results.pulse_on      = result.pulse_on;
    assign results.coil_select   = result.coil_select;
    assign results.pulse_duty    = result.pulse_duty;
    assign results.dial_position = result.dial_position;
    assign results.catching_up   = result.catching_up;

endmodule

@@ design/scpc_checker.sv @@
// Port-level checker for the stepping clock pulse controller, with its bind.
`timescale 1ns / 1ps
`include "stepping_clock_pulse_controller_defines.svh"
module scpc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] read_data,
    input logic        pulse_on,
    input logic [7:0]  pulse_duty,
    input logic [15:0] dial_position
);

    // a stalled result keeps its fields
    `SCPC_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(dial_position) && $stable(pulse_duty), "stalled result changed")

    // input side only backs up when a result is waiting on the receiver
    `SCPC_ASSERT(a_ready_low, !in_ready, out_valid && !out_ready, "items.ready low without a stalled result")

    // duty reads zero while no pulse runs
    `SCPC_ASSERT(a_idle_duty, out_valid && !pulse_on, pulse_duty == 8'd0, "duty nonzero with no pulse")

endmodule

bind stepping_clock_pulse_controller scpc_checker u_scpc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (items.ready),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .read_data     (results.read_data),
    .pulse_on      (results.pulse_on),
    .pulse_duty    (results.pulse_duty),
    .dial_position (results.dial_position)
);

@@ sim/stepping_clock_pulse_controller_tb.sv @@
// Testbench for the stepping clock pulse controller: predicts every result and compares in order.
`timescale 1ns / 1ps
module stepping_clock_pulse_controller_tb;
    import scpc_pkg::*;

    // Tracks dial, pending steps and coil drive state; holds the results still due.
    class coil_drive_tracker;
        scpc_cfg_t      timing;
        logic [15:0]    position;
        logic [15:0]    pending;
        logic [7:0]     control;
        logic           tock;
        logic           catching;
        scpc_phase_t    stage;
        logic [7:0]     ms_left;
        logic [7:0]     duty;
        scpc_result_t   due_results[$];
        int unsigned    mismatches;

        function new();
            timing   = {8'd32, 8'd60, 8'd16, 8'd80, 8'd100, 8'd32};
            position = 16'(DIAL_SECONDS - 1);
            pending  = 16'd1;
            control  = 8'd0;
            tock     = 1'b0;
            catching = 1'b0;
            stage    = PH_IDLE;
            ms_left  = 8'd0;
            duty     = 8'd0;
            mismatches = 0;
        endfunction

        function void set_timing(logic [2:0] idx, logic [7:0] v);
            case (idx)
                CFG_TICK_PULSE: timing.tick_pulse_ms         = v;
                CFG_TICK_DUTY:  timing.tick_duty             = v;
                CFG_ADJ_PULSE:  timing.adjust_pulse_ms       = v;
                CFG_ADJ_DUTY:   timing.adjust_duty           = v;
                CFG_ADJ_GAP:    timing.adjust_gap_ms         = v;
                CFG_ADJ_FIRST:  timing.adjust_first_pulse_ms = v;
                default: ;
            endcase
        endfunction

        function int unsigned outstanding();
            return due_results.size();
        endfunction

        function void step_and_pulse(logic [7:0] len, logic [7:0] d);
            int unsigned nxt;
            nxt = position;
            nxt = nxt + 1;
            // out-of-range positions also fold back to zero
            position = (nxt >= DIAL_SECONDS) ? 16'd0 : 16'(nxt);
            stage    = PH_PULSE;
            ms_left  = len;
            duty     = d;
        endfunction

        function void start_catch_up();
            if (!catching)
            begin
                catching = 1'b1;
                step_and_pulse(timing.adjust_first_pulse_ms, timing.tick_duty);
            end
        endfunction

        function void end_pulse();
            tock    = ~tock;
            stage   = PH_IDLE;
            ms_left = 8'd0;
            duty    = 8'd0;
            if (pending != 16'd0)
            begin
                pending--;
                if (pending != 16'd0)
                begin
                    stage   = PH_GAP;
                    ms_left = timing.adjust_gap_ms;
                end
                else
                    catching = 1'b0;
            end
            else
                catching = 1'b0;
        endfunction

        function void apply_item(scpc_item_t it);
            scpc_result_t r;
            logic [15:0]  rd;
            rd = 16'd0;
            case (it.opcode)
                OP_WRITE:
                    case (it.reg_index)
                        REG_POS:  position = it.write_data;
                        REG_PEND: pending  = it.write_data;
                        REG_CTRL: control  = it.write_data[7:0];
                        default: ;
                    endcase
                OP_READ:
                    case (it.reg_index)
                        REG_POS:  rd = position;
                        REG_PEND: rd = pending;
                        REG_CTRL: rd = {8'd0, control};
                        default:  rd = {15'd0, tock};
                    endcase
                OP_SECOND:
                    if (control[0])
                    begin
                        if (pending != 16'd0)
                        begin
                            if (pending != 16'hFFFF)
                                pending++;
                            start_catch_up();
                        end
                        else
                            step_and_pulse(timing.tick_pulse_ms, timing.tick_duty);
                    end
                    else if (pending != 16'd0)
                        start_catch_up();
                default:
                    if (stage != PH_IDLE)
                    begin
                        if (ms_left > 8'd1)
                            ms_left--;
                        else
                        begin
                            ms_left = 8'd0;
                            if (stage == PH_PULSE)
                                end_pulse();
                            else if (pending == 16'd1)
                                step_and_pulse(timing.tick_pulse_ms, timing.tick_duty);
                            else
                                step_and_pulse(timing.adjust_pulse_ms, timing.adjust_duty);
                        end
                    end
            endcase
            r.read_data     = rd;
            r.pulse_on      = (stage == PH_PULSE);
            r.coil_select   = tock;
            r.pulse_duty    = (stage == PH_PULSE) ? duty : 8'd0;
            r.dial_position = position;
            r.catching_up   = catching;
            due_results.push_back(r);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 200)
                $display("%0t ns: %s", $time, msg);
        endtask

        task match_result(scpc_result_t got);
            scpc_result_t want;
            string        diff;
            if (due_results.size() == 0)
            begin
                report($sformatf("result with nothing due: %h", got));
                return;
            end
            want = due_results.pop_front();
            diff = "";
            if (got.read_data !== want.read_data)
                diff = {diff, $sformatf(" read_data %0h/%0h", got.read_data, want.read_data)};
            if (got.pulse_on !== want.pulse_on)
                diff = {diff, $sformatf(" pulse_on %b/%b", got.pulse_on, want.pulse_on)};
            if (got.coil_select !== want.coil_select)
                diff = {diff, $sformatf(" coil_select %b/%b", got.coil_select,
                                        want.coil_select)};
            if (got.pulse_duty !== want.pulse_duty)
                diff = {diff, $sformatf(" pulse_duty %0d/%0d", got.pulse_duty,
                                        want.pulse_duty)};
            if (got.dial_position !== want.dial_position)
                diff = {diff, $sformatf(" dial_position %0d/%0d", got.dial_position,
                                        want.dial_position)};
            if (got.catching_up !== want.catching_up)
                diff = {diff, $sformatf(" catching_up %b/%b", got.catching_up,
                                        want.catching_up)};
            if (diff != "")
                report({"result mismatch (got/exp):", diff});
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    bit                 steady;
    int unsigned        items_sent;

    coil_drive_tracker  tracker = new();

    scpc_in_if  item_bus();
    scpc_out_if result_bus();

    stepping_clock_pulse_controller uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_bus),
        .results (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    initial
    begin
        #2000000;
        $display("stepping_clock_pulse_controller_tb: errors");
        $finish;
    end

    // result side stalls at random, except during the steady stretch
    always @(posedge clk)
    begin
        result_bus.ready <= rst_n && (steady || $urandom_range(0, 99) >= 38);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_bus.valid && item_bus.ready)
                tracker.apply_item({item_bus.opcode, item_bus.reg_index, item_bus.write_data});
            if (result_bus.valid && result_bus.ready)
                tracker.match_result({result_bus.read_data, result_bus.pulse_on,
                                      result_bus.coil_select, result_bus.pulse_duty,
                                      result_bus.dial_position, result_bus.catching_up});
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [1:0] ri,
                             input logic [15:0] d);
        while (!steady && $urandom_range(0, 99) < 38)
        begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid      <= 1'b1;
        item_bus.opcode     <= op;
        item_bus.reg_index  <= ri;
        item_bus.write_data <= d;
        do
            @(posedge clk);
        while (!item_bus.ready);
        if (!(op == OP_WRITE && ri == REG_STATUS))
            items_sent++;
    endtask

    // stop sending and wait for every due result, then for the pipeline to empty
    task automatic settle();
        item_bus.valid <= 1'b0;
        @(posedge clk);
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // psel stays high across the back-to-back register writes
    task automatic write_timing(input scpc_cfg_t c);
        logic [7:0] v [6];
        logic [2:0] idx;
        v[CFG_TICK_PULSE] = c.tick_pulse_ms;
        v[CFG_TICK_DUTY]  = c.tick_duty;
        v[CFG_ADJ_PULSE]  = c.adjust_pulse_ms;
        v[CFG_ADJ_DUTY]   = c.adjust_duty;
        v[CFG_ADJ_GAP]    = c.adjust_gap_ms;
        v[CFG_ADJ_FIRST]  = c.adjust_first_pulse_ms;
        for (int i = 0; i < 6; i++)
        begin
            idx = 3'(i);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= {24'd0, v[i]};
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            tracker.set_timing(idx, v[i]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [15:0] pick_pending();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return 16'($urandom_range(0, 4));
        else if (roll < 85)
            return $urandom_range(0, 1) ? 16'hFFFF : 16'hFFFE;
        return 16'($urandom);
    endfunction

    // one second step followed by enough millisecond ticks to run it out, more or less;
    // the tick run is kept within the items left for the current stretch
    task automatic run_sequence(input int room);
        int span;
        int roll;
        if ($urandom_range(0, 9) < 7)
            send_item(OP_WRITE, REG_PEND, pick_pending());
        if ($urandom_range(0, 9) < 3)
            send_item(OP_WRITE, REG_CTRL, 16'($urandom));
        if ($urandom_range(0, 9) < 2)
        begin
            case ($urandom_range(0, 3))
                0: send_item(OP_WRITE, REG_POS, 16'(DIAL_SECONDS - 2));
                1: send_item(OP_WRITE, REG_POS, 16'(DIAL_SECONDS - 1));
                2: send_item(OP_WRITE, REG_POS, 16'($urandom_range(DIAL_SECONDS, 65535)));
                default: send_item(OP_WRITE, REG_POS, 16'($urandom));
            endcase
        end
        send_item(OP_SECOND, 2'($urandom), 16'($urandom));
        span = tracker.timing.adjust_first_pulse_ms + tracker.timing.tick_pulse_ms
             + 3 * (tracker.timing.adjust_pulse_ms + tracker.timing.adjust_gap_ms) + 4;
        if (span > 400)
            span = 400;
        if (span > room)
            span = room;
        if (span < 1)
            span = 1;
        repeat ($urandom_range(1, span))
        begin
            roll = $urandom_range(0, 99);
            if (roll < 84)
                send_item(OP_MS, 2'($urandom), 16'($urandom));
            else if (roll < 92)
                send_item(OP_READ, 2'($urandom), 16'($urandom));
            else if (roll < 96)
                send_item(OP_SECOND, 2'($urandom), 16'($urandom));
            else
                send_item(OP_WRITE, REG_PEND, pick_pending());
        end
    endtask

    initial
    begin
        scpc_cfg_t   c;
        int unsigned goal;
        bit          paused;

        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = 32'd0;
        item_bus.valid      = 1'b0;
        item_bus.opcode     = OP_WRITE;
        item_bus.reg_index  = REG_POS;
        item_bus.write_data = 16'd0;
        result_bus.ready    = 1'b0;
        steady              = 1'b0;
        items_sent          = 0;
        paused              = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        write_timing({8'd2, 8'd255, 8'd0, 8'd1, 8'd1, 8'd1});
        @(posedge clk);

        // directed: reset values, wrap, pulse replacement, saturation, zero length
        send_item(OP_READ, REG_STATUS, 16'hFFFF);
        send_item(OP_READ, REG_POS, 16'd0);
        send_item(OP_READ, REG_PEND, 16'd0);
        send_item(OP_READ, REG_CTRL, 16'd0);
        send_item(OP_SECOND, REG_POS, 16'd0);
        send_item(OP_MS, REG_POS, 16'd0);
        send_item(OP_WRITE, REG_CTRL, 16'hFFFF);
        send_item(OP_READ, REG_CTRL, 16'd0);
        send_item(OP_SECOND, REG_POS, 16'd0);
        send_item(OP_SECOND, REG_POS, 16'd0);
        send_item(OP_MS, REG_POS, 16'd0);
        send_item(OP_MS, REG_POS, 16'd0);
        send_item(OP_WRITE, REG_STATUS, 16'h1234);
        send_item(OP_READ, REG_STATUS, 16'd0);
        send_item(OP_WRITE, REG_POS, 16'hFFFF);
        send_item(OP_SECOND, REG_POS, 16'd0);
        send_item(OP_WRITE, REG_PEND, 16'hFFFF);
        send_item(OP_SECOND, REG_POS, 16'd0);
        send_item(OP_READ, REG_PEND, 16'd0);
        send_item(OP_WRITE, REG_PEND, 16'd2);
        send_item(OP_MS, REG_POS, 16'd0);
        send_item(OP_WRITE, REG_PEND, 16'd3);
        send_item(OP_MS, REG_POS, 16'd0);
        send_item(OP_MS, REG_POS, 16'd0);
        send_item(OP_WRITE, REG_CTRL, 16'd0);

        for (int p = 0; p < 7; p++)
        begin
            settle();
            case (p)
                0: c = '0;
                1: c = '1;
                2: c = {8'd32, 8'd60, 8'd16, 8'd80, 8'd100, 8'd32};
                default:
                    c = {8'($urandom_range(0, 6)), 8'($urandom), 8'($urandom_range(0, 6)),
                         8'($urandom), 8'($urandom_range(0, 6)), 8'($urandom_range(0, 6))};
            endcase
            write_timing(c);
            @(posedge clk);
            steady = (p == 4);
            goal = items_sent + 100;
            while (items_sent < goal)
            begin
                // hold the sender until the block has drained, once
                if (p == 3 && !paused && items_sent + 50 >= goal)
                begin
                    settle();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 99) < 65)
                    run_sequence(int'(goal - items_sent));
                else
                    send_item(2'($urandom), 2'($urandom), 16'($urandom));
            end
        end
        steady = 1'b0;
        settle();

        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("stepping_clock_pulse_controller_tb: clean");
        else
            $display("stepping_clock_pulse_controller_tb: errors");
        $finish;
    end

endmodule

@@ stepping_clock_pulse_controller.f @@
+incdir+design
design/scpc_pkg.sv
design/scpc_in_if.sv
design/scpc_out_if.sv
design/scpc_cfg_regs.sv
design/scpc_core.sv
design/stepping_clock_pulse_controller.sv
design/scpc_checker.sv
sim/stepping_clock_pulse_controller_tb.sv
